@@ sv/scrc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrc_pkg
// Shared constants, codes and types for the reply frame checker.
// ----------------------------------------------------------------------------
package scrc_pkg;

    // frame limits
    localparam int MAX_FRAME   = 32;
    localparam int IDX_W       = $clog2(MAX_FRAME + 1);
    localparam int INFO_LENGTH = 18;
    localparam int CAPT_NUM    = 5;

    // delimiters
    localparam logic [7:0] START_MARK = 8'h55;
    localparam logic [7:0] END_MARK   = 8'h0d;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DELIM    = 3'd1;
    localparam logic [2:0] ST_CHECKSUM = 3'd2;
    localparam logic [2:0] ST_LENGTH   = 3'd3;
    localparam logic [2:0] ST_COMMAND  = 3'd4;
    localparam logic [2:0] ST_OVERLONG = 3'd5;

    // expected reply codes
    localparam logic [1:0] REPLY_AUTO_OFF = 2'd0;
    localparam logic [1:0] REPLY_AUTO_ON  = 2'd1;
    localparam logic [1:0] REPLY_GET_INFO = 2'd2;
    localparam logic [1:0] REPLY_UNKNOWN  = 2'd3;

    // configuration port
    localparam int         ADDR_W             = 3;
    localparam int         DATA_W             = 32;
    localparam logic [0:0] REG_EXPECTED_REPLY = 1'b0;

    typedef logic [IDX_W-1:0] idx_t;

    // byte offsets of temperature, humidity, pm2.5, fault and running
    localparam idx_t CAPT_OFFSET [CAPT_NUM] = '{
        idx_t'(7), idx_t'(9), idx_t'(11), idx_t'(14), idx_t'(15)
    };

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic       info_valid;
        logic [7:0] temperature;
        logic [7:0] humidity;
        logic [7:0] pm_level;
        logic [7:0] fault;
        logic [7:0] running;
        logic [5:0] frame_length;
    } result_t;

endpackage

@@ sv/sum_check_reply_frame_checker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sum_check_reply_frame_checker_unit
// Reply frame checker: delimiters, two's-complement sum checksum, length,
// reply command, and capture of the get-info sensor fields.
// ----------------------------------------------------------------------------
// Usage
//   Frame bytes enter one item per cycle on item_valid / item_stall, with
//   last_byte set on the final byte. Only the final byte gives a result item
//   on result_valid / result_stall: status, frame length and, for a good
//   get-info reply, the five captured sensor bytes.
//   Users set the expected reply command over the APB port (address 0) only
//   while the block is idle, which it does not enforce; reset gives get info.
//   A last byte in the input register moves into the result register once
//   that register is free (not holding a stalled result), and result_valid
//   rises with it. Bytes are taken one item per cycle while no result is
//   stalled.
//   A stalled result holds every byte: an empty input register takes one
//   more byte, then item_stall follows result_stall in the same cycle.
//   Reset clears the frame state and the valid flags of both registers; no
//   item is lost or repeated once reset is released.
// ----------------------------------------------------------------------------
module sum_check_reply_frame_checker_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scrc_pkg::ADDR_W-1:0] paddr,
    input  logic [scrc_pkg::DATA_W-1:0] pwdata,
    output logic [scrc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    // byte items
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [7:0]                  rx_byte,
    input  logic                        last_byte,
    // result items
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [2:0]                  status,
    output logic                        info_valid,
    output logic [7:0]                  temperature,
    output logic [7:0]                  humidity,
    output logic [7:0]                  pm_level,
    output logic [7:0]                  fault,
    output logic [7:0]                  running,
    output logic [5:0]                  frame_length
);

    logic              [1:0] expected_reply;
    logic                    take;
    logic                    held_valid;
    scrc_pkg::item_t         held_item;
    scrc_pkg::result_t       result;

    // register bank
    scrc_cfg_regs u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .expected_reply (expected_reply)
    );

    // input register
    scrc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .rx_byte    (rx_byte),
        .last_byte  (last_byte),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // checks and result register
    scrc_frame_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .expected_reply (expected_reply),
        .held_valid     (held_valid),
        .held_item      (held_item),
        .take           (take),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result)
    );

    // result fields
    assign status       = result.status;
    assign info_valid   = result.info_valid;
    assign temperature  = result.temperature;
    assign humidity     = result.humidity;
    assign pm_level     = result.pm_level;
    assign fault        = result.fault;
    assign running      = result.running;
    assign frame_length = result.frame_length;

endmodule

@@ sv/scrc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrc_cfg_regs
// APB register bank holding the expected reply command.
// ----------------------------------------------------------------------------
module scrc_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scrc_pkg::ADDR_W-1:0] paddr,
    input  logic [scrc_pkg::DATA_W-1:0] pwdata,
    output logic [scrc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output logic [1:0]                  expected_reply
);

    logic [1:0] expected_reply_reg;
    logic [1:0] expected_reply_next;
    logic       reg_hit;
    logic       wr_en;

    // word index decode
    assign reg_hit = (paddr[scrc_pkg::ADDR_W-1:2] == scrc_pkg::REG_EXPECTED_REPLY);
    assign wr_en   = psel && penable && pwrite && reg_hit;

    always_comb
    begin
        expected_reply_next = expected_reply_reg;
        if (wr_en)
        begin
            expected_reply_next = pwdata[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reply_reg <= scrc_pkg::REPLY_GET_INFO;
        end
        else
        begin
            expected_reply_reg <= expected_reply_next;
        end
    end

    // read back, zero outside the register list
    always_comb
    begin
        prdata = '0;
        if (reg_hit)
        begin
            prdata = {{(scrc_pkg::DATA_W - 2){1'b0}}, expected_reply_reg};
        end
    end

    assign pready         = 1'b1;
    assign expected_reply = expected_reply_reg;

endmodule

@@ sv/scrc_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrc_in_stage
// Input register for received bytes; holds an item while the checker waits.
// ----------------------------------------------------------------------------
module scrc_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [7:0]          rx_byte,
    input  logic                last_byte,
    input  logic                take,
    output logic                held_valid,
    output scrc_pkg::item_t     held_item
);

    logic            valid_reg;
    logic            valid_next;
    scrc_pkg::item_t item_reg;
    logic            load;

    // stage refills whenever it is empty or its item moves on
    assign load       = !valid_reg || take;
    assign item_stall = !load;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load && item_valid)
        begin
            item_reg.rx_byte   <= rx_byte;
            item_reg.last_byte <= last_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

@@ sv/scrc_frame_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrc_frame_check
// Frame state, running checksum, field capture and the result register.
// ----------------------------------------------------------------------------
module scrc_frame_check (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          expected_reply,
    input  logic                held_valid,
    input  scrc_pkg::item_t     held_item,
    output logic                take,
    output logic                result_valid,
    input  logic                result_stall,
    output scrc_pkg::result_t   result
);

    // frame state
    scrc_pkg::idx_t     idx_reg,   idx_next;
    logic [7:0]         sum_reg,   sum_next;
    logic [7:0]         start_reg, start_next;
    logic [7:0]         prev_reg,  prev_next;
    logic               ovl_reg,   ovl_next;
    logic [7:0]         capt_reg  [scrc_pkg::CAPT_NUM];
    logic [7:0]         capt_next [scrc_pkg::CAPT_NUM];

    // result register
    logic               result_valid_reg, result_valid_next;
    scrc_pkg::result_t  result_reg;
    scrc_pkg::result_t  result_calc;

    logic                     step;
    logic                     drop;
    logic                     ovl;
    logic [scrc_pkg::IDX_W:0] n;
    logic [2:0]               status;
    logic                     info_ok;
    logic [7:0]               sum_neg;

    // the item moves on when the result register is free
    assign take = !result_valid_reg || !result_stall;
    assign step = held_valid && take;

    assign drop    = (idx_reg >= scrc_pkg::IDX_W'(scrc_pkg::MAX_FRAME));
    assign ovl     = ovl_reg || drop;
    assign n       = {1'b0, idx_reg} + 1'b1;
    assign sum_neg = 8'(8'd0 - sum_reg);

    // checks in priority order
    always_comb
    begin
        info_ok = 1'b0;
        if (ovl)
        begin
            status = scrc_pkg::ST_OVERLONG;
        end
        else if (n < 3)
        begin
            status = scrc_pkg::ST_LENGTH;
        end
        else if ((start_reg != scrc_pkg::START_MARK) ||
                 (held_item.rx_byte != scrc_pkg::END_MARK))
        begin
            status = scrc_pkg::ST_DELIM;
        end
        else if (sum_neg != prev_reg)
        begin
            status = scrc_pkg::ST_CHECKSUM;
        end
        else
        begin
            case (expected_reply)
                scrc_pkg::REPLY_AUTO_OFF,
                scrc_pkg::REPLY_AUTO_ON:
                begin
                    status = scrc_pkg::ST_OK;
                end
                scrc_pkg::REPLY_GET_INFO:
                begin
                    if (n != (scrc_pkg::IDX_W + 1)'(scrc_pkg::INFO_LENGTH))
                    begin
                        status = scrc_pkg::ST_LENGTH;
                    end
                    else
                    begin
                        status  = scrc_pkg::ST_OK;
                        info_ok = 1'b1;
                    end
                end
                default:
                begin
                    status = scrc_pkg::ST_COMMAND;
                end
            endcase
        end
    end

    // result fields; sensor bytes zeroed unless a good get-info reply
    always_comb
    begin
        result_calc.status       = status;
        result_calc.info_valid   = info_ok;
        result_calc.temperature  = info_ok ? capt_reg[0] : 8'd0;
        result_calc.humidity     = info_ok ? capt_reg[1] : 8'd0;
        result_calc.pm_level     = info_ok ? capt_reg[2] : 8'd0;
        result_calc.fault        = info_ok ? capt_reg[3] : 8'd0;
        result_calc.running      = info_ok ? capt_reg[4] : 8'd0;
        result_calc.frame_length = ovl ? 6'(scrc_pkg::MAX_FRAME) : 6'(n);
    end

    // frame state update
    always_comb
    begin
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        start_next = start_reg;
        prev_next  = prev_reg;
        ovl_next   = ovl_reg;
        for (int k = 0; k < scrc_pkg::CAPT_NUM; k++)
        begin
            capt_next[k] = capt_reg[k];
        end
        if (step)
        begin
            if (held_item.last_byte)
            begin
                idx_next   = '0;
                sum_next   = '0;
                start_next = '0;
                prev_next  = '0;
                ovl_next   = 1'b0;
                for (int k = 0; k < scrc_pkg::CAPT_NUM; k++)
                begin
                    capt_next[k] = '0;
                end
            end
            else if (drop)
            begin
                ovl_next = 1'b1;
            end
            else
            begin
                if (idx_reg == '0)
                begin
                    start_next = held_item.rx_byte;
                end
                if (idx_reg >= scrc_pkg::IDX_W'(2))
                begin
                    sum_next = sum_reg + prev_reg;
                end
                for (int k = 0; k < scrc_pkg::CAPT_NUM; k++)
                begin
                    if (scrc_pkg::CAPT_OFFSET[k] == idx_reg)
                    begin
                        capt_next[k] = held_item.rx_byte;
                    end
                end
                prev_next = held_item.rx_byte;
                idx_next  = idx_reg + 1'b1;
            end
        end
    end

    // result handshake
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (take)
        begin
            result_valid_next = step && held_item.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg          <= '0;
            sum_reg          <= '0;
            start_reg        <= '0;
            prev_reg         <= '0;
            ovl_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int k = 0; k < scrc_pkg::CAPT_NUM; k++)
            begin
                capt_reg[k] <= '0;
            end
        end
        else
        begin
            idx_reg          <= idx_next;
            sum_reg          <= sum_next;
            start_reg        <= start_next;
            prev_reg         <= prev_next;
            ovl_reg          <= ovl_next;
            result_valid_reg <= result_valid_next;
            for (int k = 0; k < scrc_pkg::CAPT_NUM; k++)
            begin
                capt_reg[k] <= capt_next[k];
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (step && held_item.last_byte)
        begin
            result_reg <= result_calc;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
